>>> hdl/ilsb_pkg.sv
// ----------------------------------------------------------------------------
// ilsb_pkg
// Types and constants shared by the indexed scanline blitter modules.
// ----------------------------------------------------------------------------
package ilsb_pkg;

    typedef enum logic [1:0] {
        CMD_PALETTE = 2'd0,
        CMD_BLEND   = 2'd1,
        CMD_SOURCE  = 2'd2,
        CMD_DRAW    = 2'd3
    } t_cmd;

    // configuration register indexes
    localparam logic [2:0] REG_KEY   = 3'd0;
    localparam logic [2:0] REG_SCALE = 3'd1;
    localparam logic [2:0] REG_BLEND = 3'd2;
    localparam logic [2:0] REG_STEP  = 3'd3;
    localparam logic [2:0] REG_START = 3'd4;

    localparam int unsigned CFG_DATA_W  = 26;
    localparam int unsigned PAL_DEPTH   = 256;
    localparam int unsigned BLEND_DEPTH = 65536;

    // one word travelling down the pipeline
    typedef struct packed {
        t_cmd        cmd;
        logic [15:0] addr;
        logic [31:0] value;
        logic [31:0] dst;
        logic        last;
    } t_item;

    typedef struct packed {
        logic        key_en;
        logic        scale_en;
        logic        blend_en;
        logic [20:0] step;
        logic [25:0] start;
    } t_cfg;

endpackage

>>> hdl/ilsb_fetch.sv
// ----------------------------------------------------------------------------
// ilsb_fetch
// Position accumulator and source line memory: first pipeline stage.
// ----------------------------------------------------------------------------
module ilsb_fetch #(
    parameter int unsigned FRACTION_BITS = 16,
    parameter int unsigned LINE_PIXELS   = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  ilsb_pkg::t_item i_item,
    input  ilsb_pkg::t_cfg  i_cfg,
    input  logic           i_reload,
    input  logic [25:0]    i_reload_start,
    output ilsb_pkg::t_item o_item,
    output logic [7:0]     o_idx
);

    // LINE_PIXELS must be a power of two (not checked here), so the position wraps by truncation
    localparam int unsigned LW = $clog2(LINE_PIXELS);

    logic [7:0]      mem [LINE_PIXELS];
    logic [31:0]     r_acc;
    logic [31:0]     n_acc;
    logic [31:0]     step_ext;
    logic [LW-1:0]   addr;
    logic            wr;
    logic            draw;
    ilsb_pkg::t_item r_item;
    logic [7:0]      r_idx;

    assign draw     = i_vld && (i_item.cmd == ilsb_pkg::CMD_DRAW);
    assign wr       = i_vld && (i_item.cmd == ilsb_pkg::CMD_SOURCE)
                      && (i_item.addr < 16'(LINE_PIXELS));
    assign addr     = (i_item.cmd == ilsb_pkg::CMD_DRAW) ?
                      r_acc[FRACTION_BITS +: LW] : i_item.addr[LW-1:0];
    assign step_ext = {{11{i_cfg.step[20]}}, i_cfg.step};

    always_comb begin
        n_acc = r_acc;
        if (i_reload) begin
            // start_offset write: take the new value, not the old register
            n_acc = {6'd0, i_reload_start};
        end else if (draw) begin
            if (i_item.last) begin
                n_acc = {6'd0, i_cfg.start};
            end else if (i_cfg.scale_en) begin
                n_acc = r_acc + step_ext;
            end else begin
                n_acc = r_acc + (step_ext << FRACTION_BITS);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (wr) begin
                mem[addr] <= i_item.value[7:0];
            end
            r_idx  <= mem[addr];
            r_item <= i_item;
        end
    end

    assign o_item = r_item;
    assign o_idx  = r_idx;

endmodule

>>> hdl/ilsb_color.sv
// ----------------------------------------------------------------------------
// ilsb_color
// Palette memory: maps the source index to a 32-bit color word.
// ----------------------------------------------------------------------------
module ilsb_color (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic           i_vld,
    input  ilsb_pkg::t_item i_item,
    input  logic [7:0]     i_idx,
    output ilsb_pkg::t_item o_item,
    output logic [31:0]    o_color,
    output logic           o_zero
);

    logic [31:0]     mem [ilsb_pkg::PAL_DEPTH];
    logic [7:0]      addr;
    logic            wr;
    ilsb_pkg::t_item r_item;
    logic [31:0]     r_color;
    logic            r_zero;

    assign wr   = i_vld && (i_item.cmd == ilsb_pkg::CMD_PALETTE)
                  && (i_item.addr[15:8] == 8'd0);
    assign addr = (i_item.cmd == ilsb_pkg::CMD_DRAW) ? i_idx : i_item.addr[7:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (wr) begin
                mem[addr] <= i_item.value;
            end
            r_color <= mem[addr];
            r_zero  <= (i_idx == 8'd0);
            r_item  <= i_item;
        end
    end

    assign o_item  = r_item;
    assign o_color = r_color;
    assign o_zero  = r_zero;

endmodule

>>> hdl/ilsb_blend.sv
// ----------------------------------------------------------------------------
// ilsb_blend
// Blend table, one copy per color channel so all three channels are looked
// up in the same cycle. Blend loads write all copies.
// ----------------------------------------------------------------------------
module ilsb_blend (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic           i_vld,
    input  ilsb_pkg::t_item i_item,
    input  logic [31:0]    i_color,
    input  logic           i_zero,
    output ilsb_pkg::t_item o_item,
    output logic [31:0]    o_color,
    output logic           o_zero,
    output logic [2:0][7:0] o_mix
);

    logic            wr;
    ilsb_pkg::t_item r_item;
    logic [31:0]     r_color;
    logic            r_zero;
    logic [2:0][7:0] r_mix;

    assign wr = i_vld && (i_item.cmd == ilsb_pkg::CMD_BLEND);

    for (genvar k = 0; k < 3; k++) begin : g_ch
        logic [7:0]  mem [ilsb_pkg::BLEND_DEPTH];
        logic [15:0] addr;

        assign addr = (i_item.cmd == ilsb_pkg::CMD_DRAW) ?
                      {i_color[8*k +: 8], i_item.dst[8*k +: 8]} : i_item.addr;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (wr) begin
                    mem[addr] <= i_item.value[7:0];
                end
                r_mix[k] <= mem[addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item  <= i_item;
            r_color <= i_color;
            r_zero  <= i_zero;
        end
    end

    assign o_item  = r_item;
    assign o_color = r_color;
    assign o_zero  = r_zero;
    assign o_mix   = r_mix;

endmodule

>>> hdl/indexed_scanline_blitter_top.sv
// ----------------------------------------------------------------------------
// indexed_scanline_blitter_top
// Palette scanline blitter with color key and blend table.
// ----------------------------------------------------------------------------
// Input stream: one word per item. tuser carries the command (palette load,
// blend load, source load, draw), tlast marks the last draw pixel of a line,
// tdata packs address, load value and destination pixel. Output stream: one
// word per draw, none for loads; tdata is the new pixel, tuser says whether
// it was drawn (0 when keyed transparent), tlast marks the line end.
// Every item walks a four-stage pipeline: source line read, palette read,
// blend table read (one copy per channel), output register. Loads write
// their memory in the same stage that draws read it, so program order holds.
// Results leave through those stage registers in order; one item per cycle is
// sustained while the receiver keeps up, limited by each memory's single port.
// When the receiver stalls, the stages fill up behind the output register;
// the input keeps taking words until no stage is free.
// Reset clears the pipeline valids, the config registers and the position
// accumulator; the memories hold garbage until loaded. A start_offset write
// reloads the accumulator at once. Configure only while the pipe is empty.
// ----------------------------------------------------------------------------
module indexed_scanline_blitter_top #(
    parameter int unsigned FRACTION_BITS = 16,
    parameter int unsigned LINE_PIXELS   = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // entry_address, entry_value, dst_color
    input  logic [1:0]  s_axis_tuser,   // command
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // out_color
    output logic [0:0]  m_axis_tuser,   // written
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [ilsb_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    ilsb_pkg::t_cfg  r_cfg;
    ilsb_pkg::t_item in_item;
    ilsb_pkg::t_item it1, it2, it3;
    logic [7:0]      idx1;
    logic [31:0]     color2, color3;
    logic            zero2, zero3;
    logic [2:0][7:0] mix3;
    logic            r_v1, r_v2, r_v3, r_vo;
    logic            hold1, hold2, hold3, hold_o;
    logic            accept, reload;
    logic [31:0]     n_color;
    logic            n_written;
    logic [31:0]     r_color;
    logic            r_written;
    logic            r_last;

    assign in_item.cmd   = ilsb_pkg::t_cmd'(s_axis_tuser);
    assign in_item.addr  = s_axis_tdata[15:0];
    assign in_item.value = s_axis_tdata[47:16];
    assign in_item.dst   = s_axis_tdata[79:48];
    assign in_item.last  = s_axis_tlast;

    // a stage holds only when it is full and everything after it holds
    assign hold_o        = r_vo && !m_axis_tready;
    assign hold3         = r_v3 && hold_o;
    assign hold2         = r_v2 && hold3;
    assign hold1         = r_v1 && hold2;
    assign s_axis_tready = !hold1;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign reload        = i_cfg_we && (i_cfg_index == ilsb_pkg::REG_START);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key_en   <= 1'b0;
            r_cfg.scale_en <= 1'b0;
            r_cfg.blend_en <= 1'b0;
            r_cfg.step     <= 21'd1;
            r_cfg.start    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ilsb_pkg::REG_KEY:   r_cfg.key_en   <= i_cfg_data[0];
                ilsb_pkg::REG_SCALE: r_cfg.scale_en <= i_cfg_data[0];
                ilsb_pkg::REG_BLEND: r_cfg.blend_en <= i_cfg_data[0];
                ilsb_pkg::REG_STEP:  r_cfg.step     <= i_cfg_data[20:0];
                ilsb_pkg::REG_START: r_cfg.start    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ilsb_fetch #(
        .FRACTION_BITS (FRACTION_BITS),
        .LINE_PIXELS   (LINE_PIXELS)
    ) u_fetch (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (s_axis_tready),
        .i_vld          (accept),
        .i_item         (in_item),
        .i_cfg          (r_cfg),
        .i_reload       (reload),
        .i_reload_start (i_cfg_data),
        .o_item         (it1),
        .o_idx          (idx1)
    );

    ilsb_color u_color (
        .i_clk   (i_clk),
        .i_en    (!hold2),
        .i_vld   (r_v1),
        .i_item  (it1),
        .i_idx   (idx1),
        .o_item  (it2),
        .o_color (color2),
        .o_zero  (zero2)
    );

    ilsb_blend u_blend (
        .i_clk   (i_clk),
        .i_en    (!hold3),
        .i_vld   (r_v2),
        .i_item  (it2),
        .i_color (color2),
        .i_zero  (zero2),
        .o_item  (it3),
        .o_color (color3),
        .o_zero  (zero3),
        .o_mix   (mix3)
    );

    always_comb begin
        if (r_cfg.key_en && zero3) begin
            n_color   = it3.dst;
            n_written = 1'b0;
        end else if (r_cfg.blend_en) begin
            n_color   = {it3.dst[31:24], mix3[2], mix3[1], mix3[0]};
            n_written = 1'b1;
        end else begin
            n_color   = color3;
            n_written = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (!hold1) begin
                r_v1 <= accept;
            end
            if (!hold2) begin
                r_v2 <= r_v1;
            end
            if (!hold3) begin
                r_v3 <= r_v2;
            end
            if (!hold_o) begin
                r_vo <= r_v3 && (it3.cmd == ilsb_pkg::CMD_DRAW);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!hold_o) begin
            r_color   <= n_color;
            r_written <= n_written;
            r_last    <= it3.last;
        end
    end

    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata  = r_color;
    assign m_axis_tuser  = r_written;
    assign m_axis_tlast  = r_last;

    // input backs up only when every stage is full
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_v1 && r_v2 && r_v3 && r_vo))
        else $error("input stalled with a free stage");

    // loads never reach the output
    a_load_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!hold_o && r_v3 && it3.cmd != ilsb_pkg::CMD_DRAW) |=> !r_vo)
        else $error("load produced a result");

    // a stalled blend stage keeps its word
    a_stage3_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && hold_o) |=> (r_v3 && $stable(it3)))
        else $error("stage 3 word lost under stall");

    // no result shown without something in flight the cycle before
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_vo) |-> $past(r_v3))
        else $error("result without a word behind it");

endmodule
